// ===== rtl/core/gvt_pkg.sv =====
// Types and constants shared by the gravity vector tilt tracker.
package gvt_pkg;

    typedef struct packed {
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic        [17:0] step_us;
    } sample_t;

    typedef struct packed {
        logic signed [15:0] tilt_about_x;
        logic signed [15:0] tilt_about_y;
        logic signed [15:0] down_x;
        logic signed [15:0] down_y;
        logic signed [15:0] down_z;
    } result_t;

    // pi / (180 * 16 * 1e6) * 2^58
    localparam logic signed [32:0] ROT_K = 33'sd314410567;
    // blend only when 10000 * |a|^2 > 4096^2
    localparam logic [31:0] LEN2_MIN = 32'(16777216 / 10000);
    localparam logic signed [31:0] ANG90 = 32'sd377487360;
    localparam logic signed [31:0] TILT_LIMIT = 32'sd23040;
    localparam logic signed [32:0] DOWN_LIMIT = 33'sd16384;
    localparam logic [15:0] BLEND_WEIGHT_RST = 16'd60293;
    localparam int ATAN_LEN = 30;

    // atan(2^-i) in units of 2^-22 degree
    function automatic logic [27:0] atan_deg22(input logic [4:0] idx);
        logic [27:0] val;
        begin
            case (idx)
                5'd0:    val = 28'd188743680;
                5'd1:    val = 28'd111421900;
                5'd2:    val = 28'd58872272;
                5'd3:    val = 28'd29884485;
                5'd4:    val = 28'd15000234;
                5'd5:    val = 28'd7507429;
                5'd6:    val = 28'd3754631;
                5'd7:    val = 28'd1877430;
                5'd8:    val = 28'd938729;
                5'd9:    val = 28'd469366;
                5'd10:   val = 28'd234683;
                5'd11:   val = 28'd117342;
                5'd12:   val = 28'd58671;
                5'd13:   val = 28'd29335;
                5'd14:   val = 28'd14668;
                5'd15:   val = 28'd7334;
                5'd16:   val = 28'd3667;
                5'd17:   val = 28'd1833;
                5'd18:   val = 28'd917;
                5'd19:   val = 28'd458;
                5'd20:   val = 28'd229;
                5'd21:   val = 28'd115;
                5'd22:   val = 28'd57;
                5'd23:   val = 28'd29;
                5'd24:   val = 28'd14;
                5'd25:   val = 28'd7;
                5'd26:   val = 28'd4;
                5'd27:   val = 28'd2;
                5'd28:   val = 28'd1;
                default: val = 28'd0;
            endcase
            return val;
        end
    endfunction

endpackage

// ===== rtl/core/gravity_vector_tilt_tracker.sv =====
// Gravity vector tilt tracker: sequencer around one shared multiplier, divider, sqrt and CORDIC.
// One request at a time; the divider and square root run 32 iterative steps each.
// sample_stall stays high from acceptance until the result register is loaded.
// Reset: sequencer idle, no result, vector (0, 0, 1.0), blend weight 60293.
module gravity_vector_tilt_tracker #(
    parameter int GRAV_FRAC_BITS = 29,
    parameter int CORDIC_STEPS   = 20
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              blend_weight_we,
    input  logic [15:0]       blend_weight_data,
    input  logic              sample_valid,
    output logic              sample_stall,
    input  gvt_pkg::sample_t  sample,
    output logic              result_valid,
    input  logic              result_stall,
    output gvt_pkg::result_t  result
);

    localparam int CORDIC_N = (CORDIC_STEPS < gvt_pkg::ATAN_LEN) ? CORDIC_STEPS
                                                                 : gvt_pkg::ATAN_LEN;
    localparam logic [4:0] CORDIC_LAST = 5'(CORDIC_N - 1);
    localparam logic [63:0] LEN_MIN = (64'd1 << (2 * GRAV_FRAC_BITS)) / 64'd10000;
    localparam logic signed [31:0] G_ONE = 32'sd1 <<< GRAV_FRAC_BITS;
    localparam int DOWN_SHIFT = GRAV_FRAC_BITS - 14;
    localparam logic signed [32:0] DOWN_HALF = 33'sd1 <<< (GRAV_FRAC_BITS - 15);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_TH1   = 5'd1;
    localparam logic [4:0] S_TH2   = 5'd2;
    localparam logic [4:0] S_TH3   = 5'd3;
    localparam logic [4:0] S_LN1   = 5'd4;
    localparam logic [4:0] S_LN2   = 5'd5;
    localparam logic [4:0] S_CR1   = 5'd6;
    localparam logic [4:0] S_CR2   = 5'd7;
    localparam logic [4:0] S_CR3   = 5'd8;
    localparam logic [4:0] S_AN    = 5'd9;
    localparam logic [4:0] S_BL1   = 5'd10;
    localparam logic [4:0] S_BL2   = 5'd11;
    localparam logic [4:0] S_BL3   = 5'd12;
    localparam logic [4:0] S_NORM  = 5'd13;
    localparam logic [4:0] S_SS1   = 5'd14;
    localparam logic [4:0] S_SS2   = 5'd15;
    localparam logic [4:0] S_RN    = 5'd16;
    localparam logic [4:0] S_RN2   = 5'd17;
    localparam logic [4:0] S_HS1   = 5'd18;
    localparam logic [4:0] S_HS2   = 5'd19;
    localparam logic [4:0] S_HS3   = 5'd20;
    localparam logic [4:0] S_CINIT = 5'd21;
    localparam logic [4:0] S_CRUN  = 5'd22;
    localparam logic [4:0] S_CEND  = 5'd23;
    localparam logic [4:0] S_FIN   = 5'd24;
    localparam logic [4:0] S_DIV   = 5'd25;
    localparam logic [4:0] S_SQRT  = 5'd26;

    // control
    logic [4:0]         state_reg;
    logic [4:0]         ret_reg;
    logic [1:0]         comp_reg;
    logic [4:0]         it_reg;
    logic               sel_reg;
    logic               result_valid_reg;
    logic [15:0]        weight_reg;
    logic signed [31:0] g_reg [3];

    // datapath
    logic signed [15:0] gyro_reg [3];
    logic signed [15:0] accel_reg [3];
    logic [17:0]        step_reg;
    logic signed [34:0] th_reg [3];
    logic signed [37:0] r_reg [3];
    logic signed [31:0] v_reg [3];
    logic signed [37:0] tmp_reg;
    logic signed [31:0] an_reg;
    logic signed [70:0] acc_reg;
    logic [31:0]        len2_reg;
    logic [63:0]        sum_reg;
    logic               shifted_reg;
    logic signed [70:0] prod_reg;
    logic [63:0]        sq_val_reg;
    logic [33:0]        sq_rem_reg;
    logic [31:0]        sq_root_reg;
    logic [31:0]        div_rem_reg;
    logic [31:0]        div_lo_reg;
    logic [31:0]        div_den_reg;
    logic [31:0]        div_q_reg;
    logic               div_sign_reg;
    logic signed [35:0] cx_reg;
    logic signed [35:0] cy_reg;
    logic signed [31:0] cz_reg;
    logic signed [15:0] tilt_x_reg;
    logic signed [15:0] tilt_y_reg;
    gvt_pkg::result_t   result_reg;

    logic signed [37:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [70:0] th_full;
    logic signed [70:0] rnd28;
    logic signed [37:0] cr_new;
    logic signed [71:0] bl_sum;
    logic signed [71:0] bl_full;
    logic [36:0]        r_mag0;
    logic [36:0]        r_mag1;
    logic [36:0]        r_mag2;
    logic [36:0]        r_or;
    logic [2:0]         norm_shift;
    logic [63:0]        sum_new;
    logic               renorm_go;
    logic               blend_go;
    logic [15:0]        a_mag;
    logic [31:0]        v_mag;
    logic [63:0]        an_num;
    logic [63:0]        rn_num;
    logic signed [31:0] div_val;
    logic [35:0]        sq_sh;
    logic [33:0]        sq_trial;
    logic               sq_ge;
    logic [32:0]        div_trial;
    logic               div_ge;
    logic signed [35:0] cx_in;
    logic signed [35:0] cy_in;
    logic               c_zero;
    logic signed [35:0] c_dx;
    logic signed [35:0] c_dy;
    logic signed [31:0] c_ang;
    logic signed [31:0] cz_rnd;
    logic signed [15:0] cz_sat;
    logic               out_free;
    logic               last_comp;
    logic               accept;

    function automatic logic signed [15:0] down_sat(input logic signed [31:0] v);
        logic signed [32:0] d;
        logic signed [15:0] o;
        begin
            d = (33'(v) + DOWN_HALF) >>> DOWN_SHIFT;
            if (d > gvt_pkg::DOWN_LIMIT)
                o = 16'(gvt_pkg::DOWN_LIMIT);
            else if (d < -gvt_pkg::DOWN_LIMIT)
                o = 16'(-gvt_pkg::DOWN_LIMIT);
            else
                o = d[15:0];
            return o;
        end
    endfunction

    assign accept       = sample_valid && (state_reg == S_IDLE);
    assign sample_stall = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign out_free     = !(result_valid_reg && result_stall);
    assign last_comp    = (comp_reg == 2'd2);

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_TH1:
            begin
                mul_a = 38'(gyro_reg[0]);
                mul_b = $signed({15'd0, step_reg});
            end
            S_TH2:
            begin
                mul_a = 38'($signed(prod_reg[33:0]));
                mul_b = gvt_pkg::ROT_K;
            end
            S_LN1:
            begin
                mul_a = 38'(accel_reg[0]);
                mul_b = 33'(accel_reg[0]);
            end
            S_CR1:
            begin
                mul_a = 38'(th_reg[1]);
                mul_b = 33'(g_reg[2]);
            end
            S_CR2:
            begin
                mul_a = 38'(th_reg[2]);
                mul_b = 33'(g_reg[1]);
            end
            S_BL1:
            begin
                mul_a = r_reg[0];
                mul_b = $signed({17'd0, weight_reg});
            end
            S_BL2:
            begin
                mul_a = 38'(an_reg);
                mul_b = $signed({16'd0, 17'(17'h10000 - {1'b0, weight_reg})});
            end
            S_SS1:
            begin
                mul_a = 38'(v_reg[0]);
                mul_b = 33'(v_reg[0]);
            end
            S_HS1:
            begin
                mul_a = 38'(v_reg[1]);
                mul_b = 33'(v_reg[1]);
            end
            S_HS2:
            begin
                mul_a = 38'(v_reg[2]);
                mul_b = 33'(v_reg[2]);
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    assign th_full = (prod_reg + 71'sd536870912) >>> 30;
    assign rnd28   = (prod_reg + 71'sd134217728) >>> 28;
    assign cr_new  = 38'(g_reg[0]) + tmp_reg - rnd28[37:0];
    assign bl_sum  = 72'(acc_reg) + 72'(prod_reg);
    assign bl_full = (bl_sum + 72'sd32768) >>> 16;

    assign r_mag0 = r_reg[0][37] ? 37'(-r_reg[0]) : 37'(r_reg[0]);
    assign r_mag1 = r_reg[1][37] ? 37'(-r_reg[1]) : 37'(r_reg[1]);
    assign r_mag2 = r_reg[2][37] ? 37'(-r_reg[2]) : 37'(r_reg[2]);
    assign r_or   = r_mag0 | r_mag1 | r_mag2;

    always_comb
    begin
        if (r_or[36])
            norm_shift = 3'd6;
        else if (r_or[35])
            norm_shift = 3'd5;
        else if (r_or[34])
            norm_shift = 3'd4;
        else if (r_or[33])
            norm_shift = 3'd3;
        else if (r_or[32])
            norm_shift = 3'd2;
        else if (r_or[31])
            norm_shift = 3'd1;
        else
            norm_shift = 3'd0;
    end

    assign sum_new   = sum_reg + prod_reg[63:0];
    assign renorm_go = shifted_reg || (sum_new > LEN_MIN);
    assign blend_go  = (len2_reg > gvt_pkg::LEN2_MIN);

    assign a_mag  = accel_reg[0][15] ? 16'(-accel_reg[0]) : 16'(accel_reg[0]);
    assign v_mag  = v_reg[0][31] ? 32'(-v_reg[0]) : 32'(v_reg[0]);
    assign an_num = ({48'd0, a_mag} << (GRAV_FRAC_BITS + 16)) + {33'd0, sq_root_reg[31:1]};
    assign rn_num = ({32'd0, v_mag} << GRAV_FRAC_BITS) + {33'd0, sq_root_reg[31:1]};
    assign div_val = div_sign_reg ? -$signed(div_q_reg) : $signed(div_q_reg);

    assign sq_sh    = {sq_rem_reg, sq_val_reg[63:62]};
    assign sq_trial = {sq_root_reg, 2'b01};
    assign sq_ge    = (sq_sh >= {2'b00, sq_trial});

    assign div_trial = {div_rem_reg, div_lo_reg[31]};
    assign div_ge    = (div_trial >= {1'b0, div_den_reg});

    assign cx_in  = sel_reg ? 36'(v_reg[2]) : $signed({4'd0, sq_root_reg});
    assign cy_in  = sel_reg ? 36'(v_reg[1]) : 36'(v_reg[0]);
    assign c_zero = (cx_in == '0) && (cy_in == '0);
    assign c_dx   = cy_reg >>> it_reg;
    assign c_dy   = cx_reg >>> it_reg;
    assign c_ang  = $signed({4'd0, gvt_pkg::atan_deg22(it_reg)});
    assign cz_rnd = (cz_reg + 32'sd16384) >>> 15;

    always_comb
    begin
        if (cz_rnd > gvt_pkg::TILT_LIMIT)
            cz_sat = 16'(gvt_pkg::TILT_LIMIT);
        else if (cz_rnd < -gvt_pkg::TILT_LIMIT)
            cz_sat = 16'(-gvt_pkg::TILT_LIMIT);
        else
            cz_sat = cz_rnd[15:0];
    end

    // sequencer, config register, gravity state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            ret_reg          <= S_IDLE;
            comp_reg         <= 2'd0;
            it_reg           <= 5'd0;
            sel_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
            weight_reg       <= gvt_pkg::BLEND_WEIGHT_RST;
            g_reg[0]         <= '0;
            g_reg[1]         <= '0;
            g_reg[2]         <= G_ONE;
        end
        else
        begin
            if (blend_weight_we)
                weight_reg <= blend_weight_data;
            if ((state_reg == S_FIN) && out_free)
                result_valid_reg <= 1'b1;
            else if (result_valid_reg && !result_stall)
                result_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        comp_reg  <= 2'd0;
                        state_reg <= S_TH1;
                    end
                end
                S_TH1:
                    state_reg <= S_TH2;
                S_TH2:
                    state_reg <= S_TH3;
                S_TH3:
                begin
                    comp_reg  <= last_comp ? 2'd0 : comp_reg + 2'd1;
                    state_reg <= last_comp ? S_LN1 : S_TH1;
                end
                S_LN1:
                    state_reg <= S_LN2;
                S_LN2:
                begin
                    comp_reg  <= last_comp ? 2'd0 : comp_reg + 2'd1;
                    state_reg <= last_comp ? S_CR1 : S_LN1;
                end
                S_CR1:
                    state_reg <= S_CR2;
                S_CR2:
                    state_reg <= S_CR3;
                S_CR3:
                begin
                    g_reg[0] <= g_reg[1];
                    g_reg[1] <= g_reg[2];
                    g_reg[2] <= g_reg[0];
                    if (last_comp)
                    begin
                        comp_reg <= 2'd0;
                        it_reg   <= 5'd0;
                        if (blend_go)
                        begin
                            ret_reg   <= S_AN;
                            state_reg <= S_SQRT;
                        end
                        else
                            state_reg <= S_NORM;
                    end
                    else
                    begin
                        comp_reg  <= comp_reg + 2'd1;
                        state_reg <= S_CR1;
                    end
                end
                S_SQRT:
                begin
                    it_reg <= it_reg + 5'd1;
                    if (it_reg == 5'd31)
                        state_reg <= ret_reg;
                end
                S_DIV:
                begin
                    it_reg <= it_reg + 5'd1;
                    if (it_reg == 5'd31)
                        state_reg <= ret_reg;
                end
                S_AN:
                begin
                    it_reg    <= 5'd0;
                    ret_reg   <= S_BL1;
                    state_reg <= S_DIV;
                end
                S_BL1:
                    state_reg <= S_BL2;
                S_BL2:
                    state_reg <= S_BL3;
                S_BL3:
                begin
                    comp_reg  <= last_comp ? 2'd0 : comp_reg + 2'd1;
                    state_reg <= last_comp ? S_NORM : S_AN;
                end
                S_NORM:
                    state_reg <= S_SS1;
                S_SS1:
                    state_reg <= S_SS2;
                S_SS2:
                begin
                    if (last_comp)
                    begin
                        comp_reg <= 2'd0;
                        it_reg   <= 5'd0;
                        if (renorm_go)
                        begin
                            ret_reg   <= S_RN;
                            state_reg <= S_SQRT;
                        end
                        else
                            state_reg <= S_HS1;
                    end
                    else
                    begin
                        comp_reg  <= comp_reg + 2'd1;
                        state_reg <= S_SS1;
                    end
                end
                S_RN:
                begin
                    it_reg    <= 5'd0;
                    ret_reg   <= S_RN2;
                    state_reg <= S_DIV;
                end
                S_RN2:
                begin
                    comp_reg  <= last_comp ? 2'd0 : comp_reg + 2'd1;
                    state_reg <= last_comp ? S_HS1 : S_RN;
                end
                S_HS1:
                begin
                    g_reg[0]  <= v_reg[0];
                    g_reg[1]  <= v_reg[1];
                    g_reg[2]  <= v_reg[2];
                    state_reg <= S_HS2;
                end
                S_HS2:
                    state_reg <= S_HS3;
                S_HS3:
                begin
                    it_reg    <= 5'd0;
                    sel_reg   <= 1'b0;
                    ret_reg   <= S_CINIT;
                    state_reg <= S_SQRT;
                end
                S_CINIT:
                begin
                    it_reg    <= 5'd0;
                    state_reg <= c_zero ? S_CEND : S_CRUN;
                end
                S_CRUN:
                begin
                    it_reg <= it_reg + 5'd1;
                    if (it_reg == CORDIC_LAST)
                        state_reg <= S_CEND;
                end
                S_CEND:
                begin
                    sel_reg   <= 1'b1;
                    state_reg <= sel_reg ? S_FIN : S_CINIT;
                end
                S_FIN:
                begin
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    gyro_reg[0]  <= sample.gyro_x;
                    gyro_reg[1]  <= sample.gyro_y;
                    gyro_reg[2]  <= sample.gyro_z;
                    accel_reg[0] <= sample.accel_x;
                    accel_reg[1] <= sample.accel_y;
                    accel_reg[2] <= sample.accel_z;
                    step_reg     <= sample.step_us;
                    len2_reg     <= '0;
                    sum_reg      <= '0;
                end
            end
            S_TH3:
            begin
                th_reg[0]   <= th_reg[1];
                th_reg[1]   <= th_reg[2];
                th_reg[2]   <= th_full[34:0];
                gyro_reg[0] <= gyro_reg[1];
                gyro_reg[1] <= gyro_reg[2];
                gyro_reg[2] <= gyro_reg[0];
            end
            S_LN2:
            begin
                len2_reg     <= len2_reg + prod_reg[31:0];
                accel_reg[0] <= accel_reg[1];
                accel_reg[1] <= accel_reg[2];
                accel_reg[2] <= accel_reg[0];
            end
            S_CR2:
                tmp_reg <= rnd28[37:0];
            S_CR3:
            begin
                r_reg[0]  <= r_reg[1];
                r_reg[1]  <= r_reg[2];
                r_reg[2]  <= cr_new;
                th_reg[0] <= th_reg[1];
                th_reg[1] <= th_reg[2];
                th_reg[2] <= th_reg[0];
                if (last_comp)
                begin
                    sq_val_reg  <= {len2_reg, 32'd0};
                    sq_rem_reg  <= '0;
                    sq_root_reg <= '0;
                end
            end
            S_SQRT:
            begin
                sq_val_reg  <= {sq_val_reg[61:0], 2'b00};
                sq_rem_reg  <= sq_ge ? 34'(sq_sh - {2'b00, sq_trial}) : sq_sh[33:0];
                sq_root_reg <= {sq_root_reg[30:0], sq_ge};
            end
            S_DIV:
            begin
                div_rem_reg <= div_ge ? 32'(div_trial - {1'b0, div_den_reg}) : div_trial[31:0];
                div_lo_reg  <= {div_lo_reg[30:0], 1'b0};
                div_q_reg   <= {div_q_reg[30:0], div_ge};
            end
            S_AN:
            begin
                div_rem_reg  <= an_num[63:32];
                div_lo_reg   <= an_num[31:0];
                div_den_reg  <= sq_root_reg;
                div_sign_reg <= accel_reg[0][15];
            end
            S_BL1:
                an_reg <= div_val;
            S_BL2:
                acc_reg <= prod_reg;
            S_BL3:
            begin
                r_reg[0]     <= r_reg[1];
                r_reg[1]     <= r_reg[2];
                r_reg[2]     <= bl_full[37:0];
                accel_reg[0] <= accel_reg[1];
                accel_reg[1] <= accel_reg[2];
                accel_reg[2] <= accel_reg[0];
            end
            S_NORM:
            begin
                v_reg[0]    <= 32'(r_reg[0] >>> norm_shift);
                v_reg[1]    <= 32'(r_reg[1] >>> norm_shift);
                v_reg[2]    <= 32'(r_reg[2] >>> norm_shift);
                shifted_reg <= (norm_shift != 3'd0);
            end
            S_SS2:
            begin
                sum_reg  <= sum_new;
                v_reg[0] <= v_reg[1];
                v_reg[1] <= v_reg[2];
                v_reg[2] <= v_reg[0];
                if (last_comp)
                begin
                    sq_val_reg  <= sum_new;
                    sq_rem_reg  <= '0;
                    sq_root_reg <= '0;
                end
            end
            S_RN:
            begin
                div_rem_reg  <= rn_num[63:32];
                div_lo_reg   <= rn_num[31:0];
                div_den_reg  <= sq_root_reg;
                div_sign_reg <= v_reg[0][31];
            end
            S_RN2:
            begin
                v_reg[0] <= v_reg[1];
                v_reg[1] <= v_reg[2];
                v_reg[2] <= div_val;
            end
            S_HS2:
                acc_reg <= prod_reg;
            S_HS3:
            begin
                sq_val_reg  <= acc_reg[63:0] + prod_reg[63:0];
                sq_rem_reg  <= '0;
                sq_root_reg <= '0;
            end
            S_CINIT:
            begin
                if (c_zero)
                begin
                    cx_reg <= '0;
                    cy_reg <= '0;
                    cz_reg <= '0;
                end
                else if (cx_in < 0)
                begin
                    if (cy_in >= 0)
                    begin
                        cx_reg <= cy_in;
                        cy_reg <= -cx_in;
                        cz_reg <= gvt_pkg::ANG90;
                    end
                    else
                    begin
                        cx_reg <= -cy_in;
                        cy_reg <= cx_in;
                        cz_reg <= -gvt_pkg::ANG90;
                    end
                end
                else
                begin
                    cx_reg <= cx_in;
                    cy_reg <= cy_in;
                    cz_reg <= '0;
                end
            end
            S_CRUN:
            begin
                if (cy_reg > 0)
                begin
                    cx_reg <= cx_reg + c_dx;
                    cy_reg <= cy_reg - c_dy;
                    cz_reg <= cz_reg + c_ang;
                end
                else
                begin
                    cx_reg <= cx_reg - c_dx;
                    cy_reg <= cy_reg + c_dy;
                    cz_reg <= cz_reg - c_ang;
                end
            end
            S_CEND:
            begin
                if (sel_reg)
                    tilt_y_reg <= cz_sat;
                else
                    tilt_x_reg <= cz_sat;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    result_reg.tilt_about_x <= tilt_x_reg;
                    result_reg.tilt_about_y <= tilt_y_reg;
                    result_reg.down_x       <= down_sat(v_reg[0]);
                    result_reg.down_y       <= down_sat(v_reg[1]);
                    result_reg.down_z       <= down_sat(v_reg[2]);
                end
            end
            default:
            begin
                tmp_reg <= tmp_reg;
            end
        endcase
    end

endmodule
